[sv/head_tail_frame_deframer_core_macros.svh]
// Assertion macros shared by the deframer modules.
// Needs a clock named clock and an active-high reset named reset in scope.
`ifndef HEAD_TAIL_FRAME_DEFRAMER_CORE_MACROS_SVH
`define HEAD_TAIL_FRAME_DEFRAMER_CORE_MACROS_SVH

// Same-cycle implication, quiet while reset is high.
`define HTFD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, quiet while reset is high.
`define HTFD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/htfd_pkg.sv]
// Shared constants and types for the head/tail frame deframer.
// No dependencies; used by htfd_parser and head_tail_frame_deframer_core.
package htfd_pkg;

   // Payload bytes between head and tail (4 to 64).
   localparam int PAYLOAD_BYTES = 4;
   // Count must hold 0..PAYLOAD_BYTES inclusive.
   localparam int COUNT_W = $clog2(PAYLOAD_BYTES + 1);

   // Only the first four payload bytes feed the result.
   localparam int STORE_DEPTH = 4;
   localparam int STORE_IDX_W = 2;

   localparam int BYTE_W = 8;
   localparam int TIME_W = 32;
   localparam int WORD_W = 16;

   localparam int REQ_DATA_W = 40;  // rx_byte + now_ms
   localparam int RSP_DATA_W = 64;  // current_x + current_y + recv_time_ms

   // Register indexes of the configuration port.
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] REG_HEAD_BYTE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_TAIL_BYTE = 1'b1;

   // Request kinds carried in req_tuser.
   localparam logic ACTION_BYTE  = 1'b0;
   localparam logic ACTION_FLUSH = 1'b1;

   typedef struct packed {
      logic in_frame;  // parser is past the head byte
      logic at_tail;   // next byte is the tail position
      logic emit;      // current request completes a frame
   } htfd_status_type;

endpackage

[sv/htfd_parser.sv]
// Parser state for the deframer: hunt flag, payload count and payload store.
// Depends on htfd_pkg.
module htfd_parser (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step,       // consume the staged request
   input  logic                              action,
   input  logic [htfd_pkg::BYTE_W-1:0]       rx_byte,
   input  logic [htfd_pkg::BYTE_W-1:0]       head_byte,
   input  logic [htfd_pkg::BYTE_W-1:0]       tail_byte,
   output htfd_pkg::htfd_status_type         status,
   output logic [htfd_pkg::WORD_W-1:0]       coord_x,
   output logic [htfd_pkg::WORD_W-1:0]       coord_y
);

   logic                             in_frame_ff, in_frame_in;
   logic [htfd_pkg::COUNT_W-1:0]     count_ff, count_in;
   logic [htfd_pkg::BYTE_W-1:0]      store_ff [htfd_pkg::STORE_DEPTH];
   logic                             at_tail;
   logic                             is_head;
   logic                             is_tail;
   logic                             store_we;

   assign is_head = (rx_byte == head_byte);
   assign is_tail = (rx_byte == tail_byte);
   assign at_tail = in_frame_ff &&
                    (count_ff == htfd_pkg::COUNT_W'(htfd_pkg::PAYLOAD_BYTES));

   always_comb begin
      in_frame_in = in_frame_ff;
      count_in    = count_ff;
      store_we    = 1'b0;
      if (action == htfd_pkg::ACTION_FLUSH) begin
         in_frame_in = 1'b0;
         count_in    = '0;
      end else if (!in_frame_ff) begin
         if (is_head) begin
            in_frame_in = 1'b1;
            count_in    = '0;
         end
      end else if (!at_tail) begin
         // Head inside the payload is plain data.
         store_we = (count_ff < htfd_pkg::COUNT_W'(htfd_pkg::STORE_DEPTH));
         count_in = count_ff + 1'b1;
      end else if (is_tail) begin
         in_frame_in = 1'b0;
         count_in    = '0;
      end else if (is_head) begin
         // Restart the frame on a head at the tail position.
         count_in = '0;
      end else begin
         in_frame_in = 1'b0;
         count_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         count_ff    <= '0;
      end else if (step) begin
         in_frame_ff <= in_frame_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && store_we) begin
         store_ff[count_ff[htfd_pkg::STORE_IDX_W-1:0]] <= rx_byte;
      end
   end

   assign status.in_frame = in_frame_ff;
   assign status.at_tail  = at_tail;
   assign status.emit     = at_tail && (action == htfd_pkg::ACTION_BYTE) && is_tail;

   assign coord_x = {store_ff[0], store_ff[1]};
   assign coord_y = {store_ff[2], store_ff[3]};

endmodule

[sv/head_tail_frame_deframer_core.sv]
// Top level of the head/tail frame deframer: request stage, parser, result register.
// Depends on htfd_pkg, htfd_parser and head_tail_frame_deframer_core_macros.svh.
//
// Byte-stream deframer for fixed-length frames. Each request carries one received
// byte (or a flush, flagged in req_tuser) with a millisecond timestamp. The block
// hunts for the head byte, stores PAYLOAD_BYTES payload bytes (a head value inside
// the payload is data), and at the tail position emits one result when the byte
// equals the tail byte: big-endian X from payload bytes 0-1, Y from bytes 2-3, and
// the timestamp of the tail byte. A head byte at the tail position restarts the
// frame; any other byte there returns to hunting; a flush returns to hunting.
// Throughput is one request per clock unless a staged request holds, as below. A
// request accepted into the request register loads its result into the result
// register when it advances, and the result handshake is made from that register.
// The result register decouples the sides, so requests keep flowing while a result
// waits; only a request that completes a frame while the previous result is still
// unclaimed holds in the request register. Write head_byte and tail_byte over the
// csr_ port only while no request is in flight.
module head_tail_frame_deframer_core (
   input  logic                                   clock,
   input  logic                                   reset,
   // Request channel
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [htfd_pkg::REQ_DATA_W-1:0]        req_tdata,   // [7:0] rx_byte, [39:8] now_ms
   input  logic                                   req_tuser,   // [0] action (1 = flush)
   // Result channel
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [htfd_pkg::RSP_DATA_W-1:0]        rsp_tdata,   // [15:0] coord_x,
                                                               // [31:16] coord_y,
                                                               // [63:32] recv_time_ms
   // Configuration writes
   input  logic                                   csr_we,
   input  logic [htfd_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [htfd_pkg::BYTE_W-1:0]            csr_wdata
);

   `include "head_tail_frame_deframer_core_macros.svh"

   // Configuration registers
   logic [htfd_pkg::BYTE_W-1:0]     head_byte_ff;
   logic [htfd_pkg::BYTE_W-1:0]     tail_byte_ff;

   // Request stage
   logic                            s1_valid_ff, s1_valid_in;
   logic                            s1_action_ff;
   logic [htfd_pkg::BYTE_W-1:0]     s1_byte_ff;
   logic [htfd_pkg::TIME_W-1:0]     s1_time_ff;
   logic                            req_take;
   logic                            advance;

   // Result stage
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [htfd_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   htfd_pkg::htfd_status_type       status;
   logic [htfd_pkg::WORD_W-1:0]     coord_x;
   logic [htfd_pkg::WORD_W-1:0]     coord_y;

   // Register writes; an index beyond the list cannot be formed at this width.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_byte_ff <= '0;
         tail_byte_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            htfd_pkg::REG_HEAD_BYTE: head_byte_ff <= csr_wdata;
            htfd_pkg::REG_TAIL_BYTE: tail_byte_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Advance the staged request unless it completes a frame and the result
   // register is still held by the consumer.
   assign advance    = s1_valid_ff && (!status.emit || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_action_ff <= req_tuser;
         s1_byte_ff   <= req_tdata[htfd_pkg::BYTE_W-1:0];
         s1_time_ff   <= req_tdata[htfd_pkg::BYTE_W +: htfd_pkg::TIME_W];
      end
   end

   htfd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .action    (s1_action_ff),
      .rx_byte   (s1_byte_ff),
      .head_byte (head_byte_ff),
      .tail_byte (tail_byte_ff),
      .status    (status),
      .coord_x   (coord_x),
      .coord_y   (coord_y)
   );

   // Load a completed frame; drop the valid once the consumer takes it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && status.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && status.emit) begin
         rsp_data_ff <= {s1_time_ff, coord_y, coord_x};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A completed frame must show up on the result channel in the next cycle.
   `HTFD_ASSERT_NEXT(a_emit_to_rsp, advance && status.emit, rsp_valid_ff, "frame lost before result register")
   // A held request keeps its contents.
   `HTFD_ASSERT_NEXT(a_stage_hold, s1_valid_ff && !advance, s1_valid_ff && $stable(s1_byte_ff) && $stable(s1_time_ff), "staged request changed while held")
   // Only a tail-position data byte can complete a frame.
   `HTFD_ASSERT_NOW(a_emit_at_tail, status.emit, status.at_tail && status.in_frame && !s1_action_ff, "frame emitted outside tail position")
   // A flush always returns the parser to hunting.
   `HTFD_ASSERT_NEXT(a_flush_hunt, advance && (s1_action_ff == htfd_pkg::ACTION_FLUSH), !status.in_frame, "flush did not return to hunting")

endmodule
